/* rtl/wsfu_pkg.sv */
// shared types and constants of the websocket frame unmasker
package wsfu_pkg;

  // default width of the payload length and byte counter
  localparam int unsigned LENGTH_BITS_DEF = 64;

  // length codes in header byte two that select an extended length
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // byte counts of the extended length fields and of the mask key
  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;
  localparam logic [3:0] KEY_BYTES    = 4'd4;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_GOOD       = 2'd0,
    STATUS_HEADER_END = 2'd1,
    STATUS_TRUNCATED  = 2'd2
  } status_e;

  // parse phases, one-hot
  typedef enum logic [5:0] {
    PH_FIRST   = 6'b000001,
    PH_SECOND  = 6'b000010,
    PH_EXTLEN  = 6'b000100,
    PH_KEY     = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_SKIP    = 6'b100000
  } phase_e;

  // one input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } item_t;

  // result of the parser for one item
  typedef struct packed {
    logic       emit;
    logic [7:0] payload_byte;
    logic       payload_last;
    status_e    frame_status;
  } res_t;

endpackage

/* rtl/wsfu_in_if.sv */
// input channel: raw frame bytes
interface wsfu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

/* rtl/wsfu_out_if.sv */
// output channel: unmasked payload bytes and status
interface wsfu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_last;
  logic [1:0] frame_status;

  modport source (output valid, output payload_byte, output payload_last,
                  output frame_status, input ready);
  modport sink (input valid, input payload_byte, input payload_last,
                input frame_status, output ready);
endinterface

/* rtl/wsfu_parse.sv */
// frame parser: header state, mask key, payload counter and unmasking
module wsfu_parse #(
  parameter int unsigned LENGTH_BITS = wsfu_pkg::LENGTH_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  wsfu_pkg::item_t item_i,
  output wsfu_pkg::res_t  res_o
);
  import wsfu_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [3:0]             idx_q, idx_d;
  logic [6:0]             code_q, code_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic                   ovf_q, ovf_d;
  logic [31:0]            key_q, key_d;
  logic [LENGTH_BITS-1:0] cnt_q, cnt_d;

  logic [3:0]             idx_inc;
  logic [3:0]             ext_need;
  logic [LENGTH_BITS-1:0] len_shift;
  logic                   ovf_next;
  logic [LENGTH_BITS-1:0] cnt_inc;
  logic                   pay_last;
  logic [31:0]            key_sh;
  logic                   in_header;

  assign idx_inc   = idx_q + 4'd1;
  assign ext_need  = (code_q == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
  assign len_shift = {len_q[LENGTH_BITS-9:0], item_i.data_byte};
  assign ovf_next  = ovf_q | (len_q[LENGTH_BITS-1 -: 8] != 8'd0);
  assign cnt_inc   = cnt_q + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
  assign pay_last  = (cnt_inc >= len_q);
  // key byte 0 sits in the top byte
  assign key_sh    = key_q >> {~cnt_q[1:0], 3'b000};

  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    code_d    = code_q;
    len_d     = len_q;
    ovf_d     = ovf_q;
    key_d     = key_q;
    cnt_d     = cnt_q;
    in_header = 1'b1;
    res_o     = '{emit: 1'b0, payload_byte: 8'd0, payload_last: 1'b0,
                  frame_status: STATUS_GOOD};

    unique case (phase_q)
      PH_SECOND: begin
        code_d = item_i.data_byte[6:0];
        idx_d  = 4'd0;
        ovf_d  = 1'b0;
        if (item_i.data_byte[6:0] == LEN_CODE_16 ||
            item_i.data_byte[6:0] == LEN_CODE_64) begin
          len_d   = '0;
          phase_d = PH_EXTLEN;
        end else begin
          len_d   = LENGTH_BITS'(item_i.data_byte[6:0]);
          phase_d = PH_KEY;
        end
      end
      PH_EXTLEN: begin
        if (idx_inc >= ext_need) begin
          // saturate lengths beyond the counter range
          len_d   = ovf_next ? '1 : len_shift;
          ovf_d   = 1'b0;
          idx_d   = 4'd0;
          phase_d = PH_KEY;
        end else begin
          len_d = len_shift;
          ovf_d = ovf_next;
          idx_d = idx_inc;
        end
      end
      PH_KEY: begin
        key_d = {key_q[23:0], item_i.data_byte};
        idx_d = idx_inc;
        if (idx_inc >= KEY_BYTES) begin
          idx_d     = 4'd0;
          cnt_d     = '0;
          phase_d   = (len_q == '0) ? PH_SKIP : PH_PAYLOAD;
          in_header = 1'b0;
        end
      end
      PH_PAYLOAD: begin
        in_header          = 1'b0;
        cnt_d              = cnt_inc;
        res_o.emit         = 1'b1;
        res_o.payload_byte = item_i.data_byte ^ key_sh[7:0];
        res_o.payload_last = pay_last | item_i.buffer_end;
        if (item_i.buffer_end && !pay_last) begin
          res_o.frame_status = STATUS_TRUNCATED;
        end
        if (pay_last) begin
          phase_d = PH_SKIP;
        end
      end
      PH_SKIP: begin
        in_header = 1'b0;
      end
      default: begin
        idx_d   = 4'd0;
        key_d   = '0;
        phase_d = PH_SECOND;
      end
    endcase

    if (item_i.buffer_end) begin
      if (in_header) begin
        res_o = '{emit: 1'b1, payload_byte: 8'd0, payload_last: 1'b1,
                  frame_status: STATUS_HEADER_END};
      end
      phase_d = PH_FIRST;
      idx_d   = 4'd0;
      code_d  = 7'd0;
      len_d   = '0;
      ovf_d   = 1'b0;
      key_d   = '0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      idx_q   <= 4'd0;
      code_q  <= 7'd0;
      len_q   <= '0;
      ovf_q   <= 1'b0;
      key_q   <= '0;
      cnt_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      code_q  <= code_d;
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      key_q   <= key_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* rtl/websocket_frame_unmasker.sv */
// top level of the websocket frame unmasker: input register, parser, result register
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   data_byte[7:0], buffer_end
//   out_o    out  valid/ready   payload_byte[7:0], payload_last, frame_status[1:0]
//
// one item per cycle sustained while the result is not stalled,
// latency set by the input register and the result register around the parser
// an item that causes no result still passes the parser and leaves the result register empty
// reset clears the parse state and both valid flags, no clearing pass
// a stalled result holds the pipe; the input register still fills behind it
module websocket_frame_unmasker #(
  parameter int unsigned LENGTH_BITS = wsfu_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wsfu_in_if.sink     in_i,
  wsfu_out_if.source  out_o
);
  import wsfu_pkg::*;

  // input register
  logic  s1_vld_q;
  item_t s1_item_q;

  // result register
  logic  out_vld_q;
  res_t  out_res_q;

  // pipe control
  logic  out_can;
  logic  fire;
  logic  in_acc;
  res_t  res;

  // result register is free or drains this cycle
  assign out_can  = !out_vld_q || out_o.ready;
  // parser consumes the held item
  assign fire     = s1_vld_q && out_can;
  assign in_i.ready = !s1_vld_q || out_can;
  assign in_acc   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= '{data_byte: in_i.data_byte, buffer_end: in_i.buffer_end};
    end
  end

  wsfu_parse #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (s1_item_q),
    .res_o  (res)
  );

  // only items that cause a result fill the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_can) begin
      out_vld_q <= fire && res.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.emit) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.payload_byte = out_res_q.payload_byte;
  assign out_o.payload_last = out_res_q.payload_last;
  assign out_o.frame_status = out_res_q.frame_status;

endmodule

/* rtl/wsfu_checker.sv */
// port level checks of the websocket frame unmasker, bound to the top level
module wsfu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] payload_byte,
  input logic       payload_last,
  input logic [1:0] frame_status
);
  import wsfu_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte) &&
      $stable(payload_last) && $stable(frame_status))
    else $error("result changed while stalled");

  // header error carries a zero byte and closes the frame
  a_hdr_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && frame_status == STATUS_HEADER_END |->
      payload_byte == 8'd0 && payload_last)
    else $error("header error item malformed");

  // truncated payload closes the frame
  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && frame_status == STATUS_TRUNCATED |-> payload_last)
    else $error("truncated item without last");

  // status code three never shows
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> frame_status != 2'd3)
    else $error("unused status code on output");

endmodule

bind websocket_frame_unmasker wsfu_checker u_wsfu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .payload_byte (out_o.payload_byte),
  .payload_last (out_o.payload_last),
  .frame_status (out_o.frame_status)
);
